// ===== hw/rtl/ptmw_pkg.sv =====
// shared types, constants and helper functions of the page table map walker
`timescale 1ns / 1ps
`default_nettype none
package ptmw_pkg;

  // geometry of the table pool
  localparam int TABLE_PAGES_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int VA_W              = 48;
  localparam int PAGE_SHIFT        = 12;
  localparam int FRAME_W           = VA_W - PAGE_SHIFT;
  localparam int DESC_W            = 64;
  localparam int NFP_W             = 7;
  localparam int NFP_MAX           = 127;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_FIRST_FREE = 1'b1;
  localparam logic [NFP_W-1:0] FIRST_FREE_RST = 7'd1;

  // mapping modes
  localparam logic [1:0] MODE_KERNEL = 2'd0;
  localparam logic [1:0] MODE_DEVICE = 2'd1;
  localparam logic [1:0] MODE_UCODE  = 2'd2;
  localparam logic [1:0] MODE_UDATA  = 2'd3;

  // walk levels
  localparam logic [1:0] LVL_0    = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_PAGE = 2'd3;

  // descriptor bits
  localparam logic [DESC_W-1:0] BIT_UXN         = 64'h0040_0000_0000_0000;
  localparam logic [DESC_W-1:0] BIT_PXN         = 64'h0020_0000_0000_0000;
  localparam logic [DESC_W-1:0] BIT_AF          = 64'h0000_0000_0000_0400;
  localparam logic [DESC_W-1:0] INNER_SHAREABLE = 64'h0000_0000_0000_0300;
  localparam logic [DESC_W-1:0] OUTER_SHAREABLE = 64'h0000_0000_0000_0200;
  localparam logic [DESC_W-1:0] AP_EL0_RW       = 64'h0000_0000_0000_0040;
  localparam logic [DESC_W-1:0] ATTR_DEV        = 64'h0000_0000_0000_0008;
  localparam logic [DESC_W-1:0] DESC_VLD        = 64'h0000_0000_0000_0003;
  localparam logic [PAGE_SHIFT-1:0] TBL_LOW = 12'h003;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [FRAME_W-1:0] pool_frame;
    logic [NFP_W-1:0]   first_free;
    logic               load_free;
  } cfg_t;

  // table index of a virtual address at one level
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      LVL_0:   r = va[47:39];
      LVL_1:   r = va[38:30];
      LVL_2:   r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

  // level-3 page descriptor for a mode
  function automatic logic [DESC_W-1:0] make_desc(input logic [1:0] md,
                                                  input logic [VA_W-1:0] pa);
    logic [DESC_W-1:0] base;
    logic [DESC_W-1:0] extra;
    base = {16'h0000, pa[VA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} | BIT_AF | DESC_VLD;
    case (md)
      MODE_KERNEL: extra = INNER_SHAREABLE | BIT_UXN | BIT_PXN;
      MODE_DEVICE: extra = ATTR_DEV | OUTER_SHAREABLE | BIT_UXN | BIT_PXN;
      MODE_UCODE:  extra = AP_EL0_RW | INNER_SHAREABLE | BIT_PXN;
      default:     extra = AP_EL0_RW | INNER_SHAREABLE | BIT_UXN | BIT_PXN;
    endcase
    return base | extra;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ptmw_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ptmw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptmw_frame_alu.sv =====
// shared page-frame adder used for offsets, table addresses and entry addresses
`timescale 1ns / 1ps
`default_nettype none
module ptmw_frame_alu (
  input  wire logic                        sub,
  input  wire logic [ptmw_pkg::FRAME_W-1:0] a,
  input  wire logic [ptmw_pkg::FRAME_W-1:0] b,
  output logic      [ptmw_pkg::FRAME_W-1:0] y
);
  import ptmw_pkg::*;

  // frame arithmetic wraps modulo the 48-bit address space
  always_comb begin
    if (sub) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptmw_regs.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none
module ptmw_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ptmw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ptmw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ptmw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output ptmw_pkg::cfg_t                       cfg
);
  import ptmw_pkg::*;

  logic [VA_W-1:0]  pool_base;
  logic [NFP_W-1:0] first_free;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // registers sit on 8-byte boundaries
  assign reg_sel = paddr[3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      first_free <= FIRST_FREE_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_POOL_BASE) begin
        pool_base <= pwdata[VA_W-1:0];
      end else begin
        first_free <= pwdata[NFP_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (reg_sel == REG_POOL_BASE) begin
      prdata = {{(CFG_DATA_W-VA_W){1'b0}}, pool_base};
    end else begin
      prdata = {{(CFG_DATA_W-NFP_W){1'b0}}, first_free};
    end
  end

  // a write of first_free_page also restarts allocation there
  assign cfg.pool_frame = pool_base[VA_W-1:PAGE_SHIFT];
  assign cfg.first_free = pwdata[NFP_W-1:0];
  assign cfg.load_free  = wr_en & (reg_sel == REG_FIRST_FREE);

endmodule
`default_nettype wire

// ===== hw/rtl/ptmw_seq.sv =====
// walk sequencer: clearing pass, table walk, allocation and result register
`timescale 1ns / 1ps
`default_nettype none
module ptmw_seq #(
  parameter int TABLE_PAGES = ptmw_pkg::TABLE_PAGES_DEF,
  parameter int ADDR_W      = $clog2(TABLE_PAGES) + ptmw_pkg::IDX_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptmw_pkg::cfg_t                cfg,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    mode,
  input  wire logic [5:0]                    root_page,
  input  wire logic [ptmw_pkg::VA_W-1:0]     virt_addr,
  input  wire logic [ptmw_pkg::VA_W-1:0]     phys_addr,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ptmw_pkg::DESC_W-1:0]        page_descriptor,
  output logic [ptmw_pkg::VA_W-1:0]          entry_address,
  output logic [1:0]                         tables_created,
  output logic                               out_of_tables,
  // table memory
  output logic                               mem_we,
  output logic [ADDR_W-1:0]                  mem_addr,
  output logic [ptmw_pkg::DESC_W-1:0]        mem_wdata,
  input  wire logic [ptmw_pkg::DESC_W-1:0]   mem_rdata,
  // shared frame adder
  output logic                               alu_sub,
  output logic [ptmw_pkg::FRAME_W-1:0]       alu_a,
  input  wire logic [ptmw_pkg::FRAME_W-1:0]  alu_y
);
  import ptmw_pkg::*;

  localparam int PG_W        = $clog2(TABLE_PAGES);
  localparam int DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ALLOC_LIMIT = (TABLE_PAGES < NFP_MAX) ? TABLE_PAGES : NFP_MAX;
  localparam int ROOT_CMP_W  = 14;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_POST = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [1:0]        level;
  logic [PG_W-1:0]   path;
  logic [NFP_W-1:0]  nfp;
  logic [1:0]        mode_q;
  logic [VA_W-1:0]   virt_q;
  logic [VA_W-1:0]   phys_q;
  logic [DESC_W-1:0] res_desc;
  logic [VA_W-1:0]   res_entry;
  logic [1:0]        res_tables;
  logic              res_fail;

  logic [IDX_W-1:0]  cur_idx;
  logic [1:0]        need;
  logic              short;
  logic              root_out;
  logic              leaves_pool;
  logic              slot_free;
  logic              accept;
  logic              clr_done;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign slot_free = ~out_valid | out_ready;
  assign clr_done  = (clr_cnt == ADDR_W'(DEPTH - 1));

  // walk arithmetic
  assign cur_idx     = level_index(virt_q, level);
  assign need        = LVL_PAGE - level;
  assign short       = (8'(nfp) + 8'(need)) > 8'(ALLOC_LIMIT);
  assign root_out    = ROOT_CMP_W'(root_page) >= ROOT_CMP_W'(TABLE_PAGES);
  assign leaves_pool = alu_y >= FRAME_W'(TABLE_PAGES);

  // shared adder: entry offset when checking, page address otherwise
  always_comb begin
    alu_sub = (state == S_CHK);
    case (state)
      S_CHK:   alu_a = mem_rdata[VA_W-1:PAGE_SHIFT];
      S_WR:    alu_a = FRAME_W'(nfp);
      default: alu_a = FRAME_W'(path);
    endcase
  end

  // memory port
  always_comb begin
    mem_we    = (state == S_CLR) | (state == S_WR) | (state == S_FIN);
    mem_addr  = {path, cur_idx};
    mem_wdata = make_desc(mode_q, phys_q);
    case (state)
      S_CLR: begin
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_WR: begin
        mem_wdata = {{(DESC_W-VA_W){1'b0}}, alu_y, TBL_LOW};
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (clr_done) state_next = S_IDLE;
      S_IDLE: if (accept) state_next = root_out ? S_POST : S_RD;
      S_RD:   state_next = S_CHK;
      S_CHK: begin
        if (!mem_rdata[0]) begin
          state_next = short ? S_POST : S_WR;
        end else if (leaves_pool) begin
          state_next = S_POST;
        end else begin
          state_next = (level == LVL_2) ? S_FIN : S_RD;
        end
      end
      S_WR:   if (level == LVL_2) state_next = S_FIN;
      S_FIN:  state_next = S_POST;
      S_POST: if (slot_free) state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      nfp       <= FIRST_FREE_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      // allocation pointer
      if (cfg.load_free) begin
        nfp <= cfg.first_free;
      end else if (state == S_WR) begin
        nfp <= nfp + 1'b1;
      end
      // output register
      if (state == S_POST && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q     <= mode;
          phys_q     <= phys_addr;
          virt_q     <= (mode == MODE_DEVICE) ? phys_addr : virt_addr;
          path       <= PG_W'(root_page);
          level      <= LVL_0;
          res_desc   <= '0;
          res_entry  <= '0;
          res_tables <= '0;
          res_fail   <= root_out;
        end
      end
      S_CHK: begin
        if (!mem_rdata[0]) begin
          res_fail   <= short;
          res_tables <= short ? 2'd0 : need;
        end else if (leaves_pool) begin
          res_fail <= 1'b1;
        end else begin
          path  <= PG_W'(alu_y);
          level <= level + 1'b1;
        end
      end
      S_WR: begin
        path  <= PG_W'(nfp);
        level <= level + 1'b1;
      end
      S_FIN: begin
        res_desc  <= mem_wdata;
        res_entry <= {alu_y, cur_idx, 3'b000};
      end
      S_POST: begin
        if (slot_free) begin
          page_descriptor <= res_desc;
          entry_address   <= res_entry;
          tables_created  <= res_tables;
          out_of_tables   <= res_fail;
        end
      end
      default: begin
      end
    endcase
  end

  // the table memory is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table write while idle");

  // allocation pointer moves only on table creation or a config write
  a_nfp_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_WR && !cfg.load_free) |=> (nfp == $past(nfp)))
    else $error("allocation pointer moved unexpectedly");

  // a failed request reports nothing written
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_tables) |-> (tables_created == 2'd0 && page_descriptor == '0))
    else $error("failed request carries a mapping");

  // an accepted request starts its walk or fails at once
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RD || state == S_POST))
    else $error("bad state after accept");

  // the final write always uses the page level index
  a_fin_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (level == LVL_PAGE))
    else $error("final write at wrong level");

endmodule
`default_nettype wire

// ===== hw/rtl/page_table_map_walker_unit.sv =====
// top level of the page table map walker
// walk: one item at a time from accept to result valid;
//   each walked level costs a read and a check state, each new table one write,
//   the page entry one write, and the output register is then loaded;
//   a root outside the pool fails at once, a walk that fails stops after its check
// the next item is taken once the result register is loaded, which waits for a free output slot
// reset: synchronous; a clearing pass then zeroes all TABLE_PAGES*512 entries
//   before items are taken
`timescale 1ns / 1ps
`default_nettype none
module page_table_map_walker_unit #(
  parameter int TABLE_PAGES = ptmw_pkg::TABLE_PAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      mode,
  input  wire logic [5:0]                      root_page,
  input  wire logic [ptmw_pkg::VA_W-1:0]       virt_addr,
  input  wire logic [ptmw_pkg::VA_W-1:0]       phys_addr,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ptmw_pkg::DESC_W-1:0]          page_descriptor,
  output logic [ptmw_pkg::VA_W-1:0]            entry_address,
  output logic [1:0]                           tables_created,
  output logic                                 out_of_tables,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ptmw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ptmw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ptmw_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ptmw_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_PAGES) + IDX_W;
  localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;

  cfg_t               cfg;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [DESC_W-1:0]  mem_wdata;
  logic [DESC_W-1:0]  mem_rdata;
  logic               alu_sub;
  logic [FRAME_W-1:0] alu_a;
  logic [FRAME_W-1:0] alu_y;

  // configuration registers
  ptmw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared frame adder
  ptmw_frame_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (cfg.pool_frame),
    .y   (alu_y)
  );

  // table pool memory
  ptmw_ram #(
    .WIDTH (DESC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // walk sequencer
  ptmw_seq #(
    .TABLE_PAGES (TABLE_PAGES),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .root_page       (root_page),
    .virt_addr       (virt_addr),
    .phys_addr       (phys_addr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .page_descriptor (page_descriptor),
    .entry_address   (entry_address),
    .tables_created  (tables_created),
    .out_of_tables   (out_of_tables),
    .mem_we          (mem_we),
    .mem_addr        (mem_addr),
    .mem_wdata       (mem_wdata),
    .mem_rdata       (mem_rdata),
    .alu_sub         (alu_sub),
    .alu_a           (alu_a),
    .alu_y           (alu_y)
  );

endmodule
`default_nettype wire
